### src/hfti_pkg.sv
// Shared types and constants of the height-field triangle interpolator.
package hfti_pkg;

    localparam int HEIGHT_W  = 24;
    localparam int IDX_W     = 14;
    localparam int POS_W     = 15;
    localparam int DIM_W     = 8;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 8;

    // Slave-side tdata layout, lowest bits first
    localparam int IDX_LSB    = 0;
    localparam int HGT_LSB    = IDX_LSB + IDX_W;
    localparam int PX_LSB     = HGT_LSB + HEIGHT_W;
    localparam int PZ_LSB     = PX_LSB + POS_W;
    localparam int S_FIELDS_W = PZ_LSB + POS_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    localparam logic [DIM_W-1:0] DIM_RESET = 8'd128;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS  = 8'd1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT     = 2'd2;

    localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX = 24'sh7FFFFF;
    localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN = 24'sh800000;

    typedef struct packed {
        logic query;
        logic wr_ok;
        logic outside;
    } hfti_ctrl_t;

endpackage

### src/heightfield_triangle_interpolate_top.sv
// Top level of the height-field triangle interpolator.
//
//  channel  dir  handshake            words
//  s_*      in   s_tvalid/s_tready    vertex writes and height queries
//  m_*      out  m_tvalid/m_tready    one result per query
//  cfg_*    in   cfg_valid/cfg_ready  grid_width (0), grid_rows (1)
//
// One word enters per cycle while s_tready is high; a query's result passes through
// the decode, address, store read, triangle select, multiply, sum and output
// registers. The store is two mirrored copies, so four corners read in the same cycle.
// Reset clears valid bits and sets both grid registers to 128; the store is not
// cleared. Each stage holds while the next is full; empty stages close up.
module heightfield_triangle_interpolate_top #(
    parameter int GRID_SIZE = 128,
    parameter int FRAC_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // vertex_index, vertex_height, pos_x, pos_z, zero pad
    input  logic [hfti_pkg::S_TDATA_W-1:0]     s_tdata,
    // cmd
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // ground_height
    output logic [hfti_pkg::HEIGHT_W-1:0]      m_tdata,
    // status
    output logic [hfti_pkg::STATUS_W-1:0]      m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hfti_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hfti_pkg::DIM_W-1:0]         cfg_data
);
    import hfti_pkg::*;

    localparam int ADDR_W = $clog2(GRID_SIZE * GRID_SIZE);

    logic                       f_valid, f_ready;
    hfti_ctrl_t                 f_ctrl;
    logic [ADDR_W-1:0]          f_addr_lo, f_addr_hi;
    logic signed [HEIGHT_W-1:0] f_wr_data;
    logic [FRAC_BITS-1:0]       f_rx, m_rx;
    logic [FRAC_BITS:0]         f_rz, m_rz;
    logic                       m_valid, m_ready, m_outside;
    logic signed [HEIGHT_W-1:0] m_h0, m_h1, m_h2, m_h3, y_height;

    assign cfg_ready = 1'b1;

    hfti_front #(
        .GRID_SIZE (GRID_SIZE),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (s_tuser),
        .in_vidx     (s_tdata[IDX_LSB +: IDX_W]),
        .in_vheight  ($signed(s_tdata[HGT_LSB +: HEIGHT_W])),
        .in_pos_x    (s_tdata[PX_LSB +: POS_W]),
        .in_pos_z    (s_tdata[PZ_LSB +: POS_W]),
        .out_valid   (f_valid),
        .out_ready   (f_ready),
        .out_ctrl    (f_ctrl),
        .out_addr_lo (f_addr_lo),
        .out_addr_hi (f_addr_hi),
        .out_wr_data (f_wr_data),
        .out_rx      (f_rx),
        .out_rz      (f_rz)
    );

    hfti_store #(
        .GRID_SIZE (GRID_SIZE),
        .FRAC_BITS (FRAC_BITS)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (f_valid),
        .in_ready    (f_ready),
        .in_ctrl     (f_ctrl),
        .in_addr_lo  (f_addr_lo),
        .in_addr_hi  (f_addr_hi),
        .in_wr_data  (f_wr_data),
        .in_rx       (f_rx),
        .in_rz       (f_rz),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_outside (m_outside),
        .out_h0      (m_h0),
        .out_h1      (m_h1),
        .out_h2      (m_h2),
        .out_h3      (m_h3),
        .out_rx      (m_rx),
        .out_rz      (m_rz)
    );

    hfti_interp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_interp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (m_valid),
        .in_ready   (m_ready),
        .in_outside (m_outside),
        .in_h0      (m_h0),
        .in_h1      (m_h1),
        .in_h2      (m_h2),
        .in_h3      (m_h3),
        .in_rx      (m_rx),
        .in_rz      (m_rz),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_height (y_height),
        .out_status (m_tuser)
    );

    assign m_tdata = y_height;

endmodule

### src/hfti_front.sv
// Command decode, cell lookup and store address generation (two stages).
module hfti_front #(
    parameter int GRID_SIZE = 128,
    parameter int FRAC_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [hfti_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hfti_pkg::DIM_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              in_cmd,
    input  logic [hfti_pkg::IDX_W-1:0]        in_vidx,
    input  logic signed [hfti_pkg::HEIGHT_W-1:0] in_vheight,
    input  logic [hfti_pkg::POS_W-1:0]        in_pos_x,
    input  logic [hfti_pkg::POS_W-1:0]        in_pos_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output hfti_pkg::hfti_ctrl_t              out_ctrl,
    output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] out_addr_lo,
    output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] out_addr_hi,
    output logic signed [hfti_pkg::HEIGHT_W-1:0] out_wr_data,
    output logic [FRAC_BITS-1:0]              out_rx,
    output logic [FRAC_BITS:0]                out_rz
);
    import hfti_pkg::*;

    localparam int DEPTH   = GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int RC_W    = FRAC_BITS + 1;
    localparam int EXT_W   = 17;
    localparam int DIM_MAX = (GRID_SIZE < 256) ? GRID_SIZE : 255;
    localparam logic [31:0] DEPTH_L = 32'(DEPTH);

    logic [DIM_W-1:0] grid_width_reg, grid_rows_reg;
    logic [DIM_W-1:0] w_eff, r_eff;

    logic [EXT_W-1:0] px_ext, pz_ext, ci_full, cj_full;
    hfti_ctrl_t       ctrl_in;
    logic [RC_W-1:0]  rz_in;

    logic                       s1_valid_reg, s2_valid_reg;
    hfti_ctrl_t                 s1_ctrl_reg, s2_ctrl_reg;
    logic [DIM_W-1:0]           s1_ci_reg, s1_cj_reg;
    logic [IDX_W-1:0]           s1_vidx_reg;
    logic signed [HEIGHT_W-1:0] s1_vh_reg, s2_vh_reg;
    logic [FRAC_BITS-1:0]       s1_rx_reg, s2_rx_reg;
    logic [RC_W-1:0]            s1_rz_reg, s2_rz_reg;
    logic [ADDR_W-1:0]          s2_addr_lo_reg, s2_addr_hi_reg;
    logic [ADDR_W-1:0]          addr_lo_next, addr_hi_next;
    logic [EXT_W-1:0]           row_base, a_lo, a_hi;
    logic                       s1_ready, s2_ready;

    // Register values above the store's edge act as the edge
    assign w_eff = (grid_width_reg > DIM_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : grid_width_reg;
    assign r_eff = (grid_rows_reg > DIM_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : grid_rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= DIM_RESET;
            grid_rows_reg  <= DIM_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH: grid_width_reg <= cfg_data;
                REG_GRID_ROWS:  grid_rows_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Stage 1: cell indices, fractions and range checks
    assign px_ext  = EXT_W'(in_pos_x);
    assign pz_ext  = EXT_W'(in_pos_z);
    assign ci_full = px_ext >> FRAC_BITS;
    assign cj_full = pz_ext >> FRAC_BITS;
    assign rz_in   = RC_W'(1 << FRAC_BITS) - RC_W'(pz_ext[FRAC_BITS-1:0]);

    always_comb
    begin
        ctrl_in.query   = (in_cmd == CMD_QUERY);
        ctrl_in.wr_ok   = ({{(32-IDX_W){1'b0}}, in_vidx} < DEPTH_L);
        ctrl_in.outside = ((ci_full + EXT_W'(1)) >= EXT_W'(w_eff))
                       || ((cj_full + EXT_W'(1)) >= EXT_W'(r_eff));
    end

    // Stage 2: row-major addresses of the lower and upper row of the cell; a write uses its vertex index
    assign row_base = EXT_W'(s1_cj_reg) * EXT_W'(w_eff);
    assign a_lo     = row_base + EXT_W'(s1_ci_reg);
    assign a_hi     = a_lo + EXT_W'(w_eff);
    assign addr_lo_next = s1_ctrl_reg.query ? ADDR_W'(a_lo) : ADDR_W'(s1_vidx_reg);
    assign addr_hi_next = ADDR_W'(a_hi);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_ctrl_reg <= ctrl_in;
            s1_ci_reg   <= ci_full[DIM_W-1:0];
            s1_cj_reg   <= cj_full[DIM_W-1:0];
            s1_vidx_reg <= in_vidx;
            s1_vh_reg   <= in_vheight;
            s1_rx_reg   <= px_ext[FRAC_BITS-1:0];
            s1_rz_reg   <= rz_in;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_ctrl_reg    <= s1_ctrl_reg;
            s2_addr_lo_reg <= addr_lo_next;
            s2_addr_hi_reg <= addr_hi_next;
            s2_vh_reg      <= s1_vh_reg;
            s2_rx_reg      <= s1_rx_reg;
            s2_rz_reg      <= s1_rz_reg;
        end
    end

    assign out_valid   = s2_valid_reg;
    assign out_ctrl    = s2_ctrl_reg;
    assign out_addr_lo = s2_addr_lo_reg;
    assign out_addr_hi = s2_addr_hi_reg;
    assign out_wr_data = s2_vh_reg;
    assign out_rx      = s2_rx_reg;
    assign out_rz      = s2_rz_reg;

endmodule

### src/hfti_store.sv
// Vertex height store: two mirrored copies, each one write and two reads a cycle.
module hfti_store #(
    parameter int GRID_SIZE = 128,
    parameter int FRAC_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  hfti_pkg::hfti_ctrl_t                 in_ctrl,
    input  logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] in_addr_lo,
    input  logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] in_addr_hi,
    input  logic signed [hfti_pkg::HEIGHT_W-1:0] in_wr_data,
    input  logic [FRAC_BITS-1:0]                 in_rx,
    input  logic [FRAC_BITS:0]                   in_rz,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 out_outside,
    output logic signed [hfti_pkg::HEIGHT_W-1:0] out_h0,
    output logic signed [hfti_pkg::HEIGHT_W-1:0] out_h1,
    output logic signed [hfti_pkg::HEIGHT_W-1:0] out_h2,
    output logic signed [hfti_pkg::HEIGHT_W-1:0] out_h3,
    output logic [FRAC_BITS-1:0]                 out_rx,
    output logic [FRAC_BITS:0]                   out_rz
);
    import hfti_pkg::*;

    localparam int DEPTH  = GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);

    // Copy a serves the lower row of a cell, copy b the upper row
    logic [HEIGHT_W-1:0] mem_a [DEPTH];
    logic [HEIGHT_W-1:0] mem_b [DEPTH];

    logic                 v_reg;
    logic                 outside_reg;
    logic [HEIGHT_W-1:0]  h0_reg, h1_reg, h2_reg, h3_reg;
    logic [FRAC_BITS-1:0] rx_reg;
    logic [FRAC_BITS:0]   rz_reg;
    logic [ADDR_W-1:0]    addr_lo_nx, addr_hi_nx;
    logic                 adv, wr_en, rd_en;

    assign in_ready   = !v_reg || out_ready;
    assign adv        = in_valid && in_ready;
    // Writes and reads take place at the same stage, so program order holds
    assign wr_en      = adv && !in_ctrl.query && in_ctrl.wr_ok;
    assign rd_en      = adv && in_ctrl.query;
    assign addr_lo_nx = in_addr_lo + ADDR_W'(1);
    assign addr_hi_nx = in_addr_hi + ADDR_W'(1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[in_addr_lo] <= in_wr_data;
            mem_b[in_addr_lo] <= in_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            h3_reg      <= mem_a[in_addr_lo];
            h2_reg      <= mem_a[addr_lo_nx];
            h0_reg      <= mem_b[in_addr_hi];
            h1_reg      <= mem_b[addr_hi_nx];
            outside_reg <= in_ctrl.outside;
            rx_reg      <= in_rx;
            rz_reg      <= in_rz;
        end
    end

    // Write words end here; only queries go on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid && in_ctrl.query;
    end

    assign out_valid   = v_reg;
    assign out_outside = outside_reg;
    assign out_h0      = h0_reg;
    assign out_h1      = h1_reg;
    assign out_h2      = h2_reg;
    assign out_h3      = h3_reg;
    assign out_rx      = rx_reg;
    assign out_rz      = rz_reg;

endmodule

### src/hfti_interp.sv
// Triangle select, weighting multiplies, sum, rounding and saturation.
module hfti_interp #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 in_outside,
    input  logic signed [hfti_pkg::HEIGHT_W-1:0] in_h0,
    input  logic signed [hfti_pkg::HEIGHT_W-1:0] in_h1,
    input  logic signed [hfti_pkg::HEIGHT_W-1:0] in_h2,
    input  logic signed [hfti_pkg::HEIGHT_W-1:0] in_h3,
    input  logic [FRAC_BITS-1:0]                 in_rx,
    input  logic [FRAC_BITS:0]                   in_rz,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [hfti_pkg::HEIGHT_W-1:0] out_height,
    output logic [hfti_pkg::STATUS_W-1:0]        out_status
);
    import hfti_pkg::*;

    localparam int RC_W   = FRAC_BITS + 1;
    localparam int DIFF_W = HEIGHT_W + 1;
    localparam int PROD_W = DIFF_W + RC_W + 1;
    localparam int ACC_W  = HEIGHT_W + FRAC_BITS + 4;
    localparam int Y_W    = ACC_W - FRAC_BITS;
    // 2^(FRAC_BITS-1) height units plus the rounding bias of the final shift
    localparam logic signed [ACC_W-1:0] ROUND_K =
        ACC_W'((64'd1 << (2 * FRAC_BITS - 1)) + (64'd1 << (FRAC_BITS - 1)));

    logic                     rdy4, rdy5, rdy6, rdy_out;
    logic                     s4_valid_reg, s5_valid_reg, s6_valid_reg, out_valid_reg;
    logic                     s4_outside_reg, s5_outside_reg, s6_outside_reg;

    logic                     upper;
    logic signed [DIFF_W-1:0] d1, d2;
    logic [RC_W-1:0]          c1, c2, rx_ext;

    logic signed [HEIGHT_W-1:0] s4_h0_reg, s5_h0_reg;
    logic signed [DIFF_W-1:0]   s4_d1_reg, s4_d2_reg;
    logic [RC_W-1:0]            s4_c1_reg, s4_c2_reg;
    logic signed [PROD_W-1:0]   p1, p2, s5_p1_reg, s5_p2_reg;
    logic signed [ACC_W-1:0]    acc, s6_acc_reg;
    logic signed [Y_W-1:0]      y;

    logic signed [HEIGHT_W-1:0] height_next, out_height_reg;
    logic [STATUS_W-1:0]        status_next, out_status_reg;

    assign rdy_out  = !out_valid_reg || out_ready;
    assign rdy6     = !s6_valid_reg || rdy_out;
    assign rdy5     = !s5_valid_reg || rdy6;
    assign rdy4     = !s4_valid_reg || rdy5;
    assign in_ready = rdy4;

    // Stage 4: upper-right triangle when rx > rz
    assign rx_ext = RC_W'(in_rx);
    assign upper  = rx_ext > in_rz;
    assign d1     = upper ? DIFF_W'(in_h1) - DIFF_W'(in_h0) : DIFF_W'(in_h3) - DIFF_W'(in_h0);
    assign d2     = upper ? DIFF_W'(in_h2) - DIFF_W'(in_h1) : DIFF_W'(in_h2) - DIFF_W'(in_h3);
    assign c1     = upper ? rx_ext : in_rz;
    assign c2     = upper ? in_rz : rx_ext;

    // Stage 5: two independent multiplies
    assign p1 = PROD_W'(s4_d1_reg) * PROD_W'($signed({1'b0, s4_c1_reg}));
    assign p2 = PROD_W'(s4_d2_reg) * PROD_W'($signed({1'b0, s4_c2_reg}));

    // Stage 6: exact sum with FRAC_BITS fraction bits
    assign acc = (ACC_W'(s5_h0_reg) <<< FRAC_BITS) + ACC_W'(s5_p1_reg) + ACC_W'(s5_p2_reg)
               + ROUND_K;

    // Output stage: arithmetic shift floors, bias already added
    assign y = s6_acc_reg[ACC_W-1:FRAC_BITS];

    always_comb
    begin
        priority if (s6_outside_reg)
        begin
            height_next = '0;
            status_next = ST_OUTSIDE;
        end
        else if (y > Y_W'(HEIGHT_MAX))
        begin
            height_next = HEIGHT_MAX;
            status_next = ST_SAT;
        end
        else if (y < Y_W'(HEIGHT_MIN))
        begin
            height_next = HEIGHT_MIN;
            status_next = ST_SAT;
        end
        else
        begin
            height_next = y[HEIGHT_W-1:0];
            status_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy4)
                s4_valid_reg <= in_valid;
            if (rdy5)
                s5_valid_reg <= s4_valid_reg;
            if (rdy6)
                s6_valid_reg <= s5_valid_reg;
            if (rdy_out)
                out_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && in_valid)
        begin
            s4_outside_reg <= in_outside;
            s4_h0_reg      <= in_h0;
            s4_d1_reg      <= d1;
            s4_d2_reg      <= d2;
            s4_c1_reg      <= c1;
            s4_c2_reg      <= c2;
        end
        if (rdy5 && s4_valid_reg)
        begin
            s5_outside_reg <= s4_outside_reg;
            s5_h0_reg      <= s4_h0_reg;
            s5_p1_reg      <= p1;
            s5_p2_reg      <= p2;
        end
        if (rdy6 && s5_valid_reg)
        begin
            s6_outside_reg <= s5_outside_reg;
            s6_acc_reg     <= acc;
        end
        if (rdy_out && s6_valid_reg)
        begin
            out_height_reg <= height_next;
            out_status_reg <= status_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_height = out_height_reg;
    assign out_status = out_status_reg;

endmodule

### src/hfti_checker.sv
// Port-level checks of the interpolator's result channel, bound to the top level.
module hfti_props (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [hfti_pkg::HEIGHT_W-1:0] m_tdata,
    input logic [hfti_pkg::STATUS_W-1:0] m_tuser
);
    import hfti_pkg::*;

    // a result waiting to be taken stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_OUTSIDE || m_tuser == ST_SAT))
        else $error("undefined status code");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_OUTSIDE |-> m_tdata == '0)
        else $error("outside-grid result not zero");

    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_SAT
            |-> (m_tdata == HEIGHT_MAX || m_tdata == HEIGHT_MIN))
        else $error("saturated result not at a rail");

endmodule

bind heightfield_triangle_interpolate_top hfti_props u_hfti_checker (.*);

### dv/hfti_checker.sv
// Watches the stream and register channels of the interpolator, predicts each result and compares.
module hfti_checker #(
    parameter int GRID_SIZE = 128,
    parameter int FRAC_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    // vertex_index, vertex_height, pos_x, pos_z, zero pad
    input  logic [hfti_pkg::S_TDATA_W-1:0]     s_tdata,
    // cmd
    input  logic                               s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    // ground_height
    input  logic [hfti_pkg::HEIGHT_W-1:0]      m_tdata,
    // status
    input  logic [hfti_pkg::STATUS_W-1:0]      m_tuser,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [hfti_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hfti_pkg::DIM_W-1:0]         cfg_data,
    output int                                 failures,
    output int                                 results_due
);

    timeunit 1ns;
    timeprecision 1ps;

    import hfti_pkg::*;

    localparam int STORE_DEPTH = GRID_SIZE * GRID_SIZE;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height;
        logic [STATUS_W-1:0]        status;
    } ground_t;

    logic signed [HEIGHT_W-1:0] vertex_heights [STORE_DEPTH];
    logic [DIM_W-1:0]           grid_width;
    logic [DIM_W-1:0]           grid_rows;
    ground_t                    ground_due [$];
    ground_t                    want;
    int unsigned                vtx;

    function automatic ground_t interpolate_ground(logic [POS_W-1:0] px, logic [POS_W-1:0] pz);
        int unsigned w;
        int unsigned r;
        int unsigned ci;
        int unsigned cj;
        longint      h0;
        longint      h1;
        longint      h2;
        longint      h3;
        longint      rx;
        longint      rz;
        longint      acc;
        longint      y;
        ground_t     g;
        w  = (grid_width > GRID_SIZE) ? GRID_SIZE : grid_width;
        r  = (grid_rows > GRID_SIZE) ? GRID_SIZE : grid_rows;
        ci = px >> FRAC_BITS;
        cj = pz >> FRAC_BITS;
        g.status = ST_OK;
        if (ci + 1 >= w || cj + 1 >= r) begin
            g.height = '0;
            g.status = ST_OUTSIDE;
            return g;
        end
        h3 = vertex_heights[cj * w + ci];
        h2 = vertex_heights[cj * w + ci + 1];
        h0 = vertex_heights[(cj + 1) * w + ci];
        h1 = vertex_heights[(cj + 1) * w + ci + 1];
        rx = longint'(px[FRAC_BITS-1:0]);
        rz = (longint'(1) << FRAC_BITS) - longint'(pz[FRAC_BITS-1:0]);
        acc = h0 * (longint'(1) << FRAC_BITS);
        // upper-right triangle when rx > rz, lower-left otherwise
        if (rx > rz)
        begin
            acc += (h1 - h0) * rx + (h2 - h1) * rz;
        end
        else
        begin
            acc += (h3 - h0) * rz + (h2 - h3) * rx;
        end
        acc += longint'(1) << (2 * FRAC_BITS - 1);
        // nearest, ties upward
        y = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (y > longint'(HEIGHT_MAX))
        begin
            y = longint'(HEIGHT_MAX);
            g.status = ST_SAT;
        end
        else if (y < longint'(HEIGHT_MIN))
        begin
            y = longint'(HEIGHT_MIN);
            g.status = ST_SAT;
        end
        g.height = y[HEIGHT_W-1:0];
        return g;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width <= DIM_RESET;
            grid_rows  <= DIM_RESET;
            ground_due.delete();
            results_due <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (ground_due.size() == 0)
                begin
                    $error("unexpected word: ground_height %0d status %0d",
                           $signed(m_tdata), m_tuser);
                    failures++;
                end
                else
                begin
                    want = ground_due.pop_front();
                    if (m_tdata !== want.height)
                    begin
                        $error("ground_height: expected %0d, got %0d",
                               $signed(want.height), $signed(m_tdata));
                        failures++;
                    end
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        failures++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == CMD_WRITE)
                begin
                    vtx = 32'(s_tdata[IDX_LSB +: IDX_W]);
                    if (vtx < STORE_DEPTH)
                        vertex_heights[vtx] = s_tdata[HGT_LSB +: HEIGHT_W];
                end
                else
                begin
                    ground_due.push_back(interpolate_ground(s_tdata[PX_LSB +: POS_W],
                                                            s_tdata[PZ_LSB +: POS_W]));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_GRID_WIDTH)
                    grid_width <= cfg_data;
                else if (cfg_index == REG_GRID_ROWS)
                    grid_rows <= cfg_data;
            end
            results_due <= ground_due.size();
        end
    end

endmodule

### dv/tb_top.sv
// Testbench top: clock, reset, stimulus for the interpolator and the final verdict.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import hfti_pkg::*;

    localparam int GRID_SIZE   = 128;
    localparam int FRAC_BITS   = 8;
    localparam int STORE_DEPTH = GRID_SIZE * GRID_SIZE;
    localparam int PHASES      = 14;
    localparam int PHASE_ITEMS = 135;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_GRID_ROWS + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [HEIGHT_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [DIM_W-1:0]      cfg_data;

    int          failures;
    int          results_due;
    bit          vertex_written [STORE_DEPTH];
    int unsigned grid_w;
    int unsigned grid_r;
    bit          have_patch;
    int unsigned patch_i0;
    int unsigned patch_j0;
    int unsigned patch_cols;
    int unsigned patch_rows;
    int          send_mode = 0;
    int          recv_mode = 0;
    int          recv_stall;

    heightfield_triangle_interpolate_top #(
        .GRID_SIZE (GRID_SIZE),
        .FRAC_BITS (FRAC_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hfti_checker #(
        .GRID_SIZE (GRID_SIZE),
        .FRAC_BITS (FRAC_BITS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .results_due (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    // mode 0 never idles, 1 idles lightly, 2 heavily; long gaps are rare
    function automatic int pick_idle(int mode);
        int roll;
        roll = $urandom % 16;
        if (mode == 0)
            return 0;
        if (mode == 1)
            return (roll < 11) ? 0 : (roll < 15) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        return (roll < 6) ? 0 : (roll < 14) ? $urandom_range(1, 4) : $urandom_range(20, 60);
    endfunction

    function automatic int unsigned eff_dim(logic [DIM_W-1:0] d);
        return (d > GRID_SIZE) ? GRID_SIZE : d;
    endfunction

    function automatic logic [HEIGHT_W-1:0] pick_height();
        int roll;
        roll = $urandom % 8;
        if (roll < 4)
            return HEIGHT_W'($urandom);
        if (roll < 6)
            return HEIGHT_W'($signed($urandom_range(0, 4000)) - 2000);
        if (roll == 6)
            return HEIGHT_MAX - HEIGHT_W'($urandom_range(0, 300));
        return HEIGHT_MIN + HEIGHT_W'($urandom_range(0, 300));
    endfunction

    function automatic logic [FRAC_BITS-1:0] pick_frac();
        unique case ($urandom % 6)
            0:       return '0;
            1:       return '1;
            2:       return 8'h80;
            default: return FRAC_BITS'($urandom);
        endcase
    endfunction

    // true unless the query would read a vertex that was never loaded
    function automatic bit corners_loaded(logic [POS_W-1:0] px, logic [POS_W-1:0] pz);
        int unsigned ci;
        int unsigned cj;
        ci = px >> FRAC_BITS;
        cj = pz >> FRAC_BITS;
        if (ci + 1 >= grid_w || cj + 1 >= grid_r)
            return 1'b1;
        return vertex_written[cj * grid_w + ci] && vertex_written[cj * grid_w + ci + 1]
            && vertex_written[(cj + 1) * grid_w + ci]
            && vertex_written[(cj + 1) * grid_w + ci + 1];
    endfunction

    task automatic send_word(logic cmd, logic [IDX_W-1:0] idx, logic [HEIGHT_W-1:0] hgt,
                             logic [POS_W-1:0] px, logic [POS_W-1:0] pz);
        int                   gap;
        logic [S_TDATA_W-1:0] word;
        gap  = pick_idle(send_mode);
        word = '0;
        word[IDX_LSB +: IDX_W]    = idx;
        word[HGT_LSB +: HEIGHT_W] = hgt;
        word[PX_LSB +: POS_W]     = px;
        word[PZ_LSB +: POS_W]     = pz;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= word;
        do @(posedge clk); while (!s_tready);
        if (cmd == CMD_WRITE)
            vertex_written[idx] = 1'b1;
    endtask

    task automatic load_vertex(int unsigned i, int unsigned j, logic [HEIGHT_W-1:0] hgt);
        send_word(CMD_WRITE, IDX_W'(j * grid_w + i), hgt, POS_W'($urandom), POS_W'($urandom));
    endtask

    task automatic query_at(logic [POS_W-1:0] px, logic [POS_W-1:0] pz);
        // push a position that would hit unloaded corners off the grid instead
        if (!corners_loaded(px, pz))
            px[POS_W-1:FRAC_BITS] = '1;
        send_word(CMD_QUERY, IDX_W'($urandom), HEIGHT_W'($urandom), px, pz);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (results_due != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_grid(logic [DIM_W-1:0] w, logic [DIM_W-1:0] r);
        hold_until_drained();
        // writes leave no result, so let the pipe empty before retuning
        repeat (12) @(posedge clk);
        if ($urandom % 3 == 0)
            write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                      DIM_W'($urandom));
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_ROWS, r);
        grid_w = eff_dim(w);
        grid_r = eff_dim(r);
    endtask

    task automatic load_patch();
        int unsigned i;
        int unsigned j;
        have_patch = (grid_w >= 2 && grid_r >= 2);
        if (!have_patch)
            return;
        if (grid_w <= 9)
        begin
            patch_cols = grid_w - 1;
            patch_i0   = 0;
        end
        else
        begin
            patch_cols = $urandom_range(1, 5);
            patch_i0   = ($urandom % 2) ? grid_w - 1 - patch_cols
                                        : $urandom_range(0, grid_w - 1 - patch_cols);
        end
        if (grid_r <= 9)
        begin
            patch_rows = grid_r - 1;
            patch_j0   = 0;
        end
        else
        begin
            patch_rows = $urandom_range(1, 5);
            patch_j0   = ($urandom % 2) ? grid_r - 1 - patch_rows
                                        : $urandom_range(0, grid_r - 1 - patch_rows);
        end
        for (j = patch_j0; j <= patch_j0 + patch_rows; j++)
            for (i = patch_i0; i <= patch_i0 + patch_cols; i++)
                load_vertex(i, j, pick_height());
    endtask

    task automatic run_random(int count);
        int                   roll;
        int unsigned          ci;
        int unsigned          cj;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fz;
        for (int k = 0; k < count; k++)
        begin
            roll = $urandom % 20;
            if (have_patch && roll < 11)
            begin
                ci = $urandom_range(patch_i0, patch_i0 + patch_cols - 1);
                cj = $urandom_range(patch_j0, patch_j0 + patch_rows - 1);
                fz = pick_frac();
                // rx equal to rz sits on the diagonal
                fx = ($urandom % 6 == 0) ? FRAC_BITS'(256 - fz) : pick_frac();
                query_at(POS_W'(ci * 256 + fx), POS_W'(cj * 256 + fz));
            end
            else if (have_patch && roll < 14)
            begin
                load_vertex($urandom_range(patch_i0, patch_i0 + patch_cols),
                            $urandom_range(patch_j0, patch_j0 + patch_rows), pick_height());
            end
            else if (roll < 16)
            begin
                // just on or beyond the grid border
                if ($urandom % 2)
                    query_at(POS_W'((grid_w - 1 + $urandom % 2) * 256 + $urandom % 256),
                             POS_W'($urandom_range(0, grid_r) * 256 + $urandom % 256));
                else
                    query_at(POS_W'($urandom_range(0, grid_w) * 256 + $urandom % 256),
                             POS_W'((grid_r - 1 + $urandom % 2) * 256 + $urandom % 256));
            end
            else if (roll < 18)
            begin
                query_at(POS_W'($urandom), POS_W'($urandom));
            end
            else
            begin
                send_word(CMD_WRITE, IDX_W'($urandom), pick_height(),
                          POS_W'($urandom), POS_W'($urandom));
            end
            if ($urandom % 150 == 0)
                hold_until_drained();
        end
    endtask

    initial
    begin
        logic [DIM_W-1:0] phase_w [PHASES];
        logic [DIM_W-1:0] phase_r [PHASES];
        phase_w = '{2, 255, 2, 0, 6, 128, 1, 3, 9, 200, 17, 128, 8'd0, 8'd0};
        phase_r = '{2, 2, 255, 7, 1, 128, 5, 4, 3, 130, 6, 2, 8'd0, 8'd0};
        phase_w[PHASES-2] = DIM_W'($urandom_range(2, 255));
        phase_r[PHASES-2] = DIM_W'($urandom_range(2, 255));
        phase_w[PHASES-1] = DIM_W'($urandom_range(0, 12));
        phase_r[PHASES-1] = DIM_W'($urandom_range(0, 12));

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = CMD_WRITE;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        grid_w    = GRID_SIZE;
        grid_r    = GRID_SIZE;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // out-of-list register indexes must leave the 128 x 128 reset grid alone
        write_reg(REG_SPARE_FIRST, 8'd3);
        write_reg(REG_SPARE_LAST, 8'd0);

        // cell (0,0) with the full height range
        send_word(CMD_WRITE, 14'd0, HEIGHT_MIN, 15'd0, 15'd0);
        send_word(CMD_WRITE, 14'd1, HEIGHT_MAX, '1, '1);
        send_word(CMD_WRITE, 14'd128, '0, 15'd0, 15'd0);
        send_word(CMD_WRITE, 14'd129, HEIGHT_MIN, '1, '1);
        query_at(15'd0, 15'd0);
        query_at(15'd255, 15'd255);
        query_at(15'd128, 15'd128);
        query_at(15'd255, 15'd0);
        query_at(15'd0, 15'd255);
        // far corner cell at the top of the range: saturates
        send_word(CMD_WRITE, 14'd16254, HEIGHT_MAX, '0, '0);
        send_word(CMD_WRITE, 14'd16255, HEIGHT_MAX, '0, '0);
        send_word(CMD_WRITE, 14'd16382, HEIGHT_MAX, '0, '0);
        send_word(CMD_WRITE, '1, HEIGHT_MAX, '0, '0);
        query_at(15'd32511, 15'd32511);
        query_at(15'd32320, 15'd32456);
        // off the grid
        query_at('1, 15'd0);
        query_at(15'd0, '1);
        query_at('1, '1);
        query_at(15'd32512, 15'd32512);

        for (int p = 0; p < PHASES; p++)
        begin
            set_grid(phase_w[p], phase_r[p]);
            send_mode = $urandom % 3;
            recv_mode = $urandom % 3;
            load_patch();
            run_random(PHASE_ITEMS);
        end

        hold_until_drained();
        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        m_tready   = 1'b0;
        recv_stall = 0;
        forever
        begin
            @(posedge clk);
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                recv_stall = pick_idle(recv_mode);
            end
        end
    end

endmodule
